@@ hdl/slr_pkg.sv @@
`default_nettype none
package slr_pkg;

   // Sample and phase formats.
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int STEP_BITS   = 19;
   // Phase holds up to one fraction short of one plus the largest step.
   localparam int PHASE_BITS  = FRAC_BITS + 3;
   localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

   localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;

   // Step limits.
   localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(5461);
   localparam logic [STEP_BITS-1:0] STEP_MAX   = STEP_BITS'(262144);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);

   // Output frames per source frame at most.
   localparam int MAX_RESULTS = 13;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   // Register file.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_PHASE_STEP = '0;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          write_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic                          last_of_run;
      logic                          ends_write;
   } rsp_type;

   // Command to the shared multiply-add unit.
   typedef struct packed {
      logic                          load;
      logic signed [SAMPLE_BITS-1:0] prev;
      logic signed [SAMPLE_BITS-1:0] cur;
      logic        [FRAC_BITS-1:0]   phase;
   } mac_cmd_type;

endpackage
`default_nettype wire

@@ hdl/slr_csr.sv @@
`default_nettype none
module slr_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [slr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [slr_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [slr_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready,
   output logic      [slr_pkg::STEP_BITS-1:0]         step,
   output logic                                       step_write
);

   logic [slr_pkg::STEP_BITS-1:0]     step_ff;
   logic [slr_pkg::STEP_BITS-1:0]     step_in;
   logic [slr_pkg::STEP_BITS-1:0]     wdata;
   logic [slr_pkg::CSR_ADDR_BITS-3:0] reg_index;
   logic                              hit;

   assign reg_index = paddr[slr_pkg::CSR_ADDR_BITS-1:2];
   assign hit       = (reg_index == slr_pkg::REG_PHASE_STEP);

   // A write completes in the access cycle.
   assign step_write = psel && penable && pwrite && hit;

   // Saturate the written step into its legal range.
   assign wdata = pwdata[slr_pkg::STEP_BITS-1:0];
   always_comb begin
      step_in = step_ff;
      if (step_write) begin
         if (wdata < slr_pkg::STEP_MIN) begin
            step_in = slr_pkg::STEP_MIN;
         end else if (wdata > slr_pkg::STEP_MAX) begin
            step_in = slr_pkg::STEP_MAX;
         end else begin
            step_in = wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= slr_pkg::STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step   = step_ff;
   assign pready = 1'b1;
   assign prdata = hit ? slr_pkg::CSR_DATA_BITS'(step_ff) : '0;

endmodule
`default_nettype wire

@@ hdl/slr_mac.sv @@
`default_nettype none
module slr_mac (
   input  wire logic                                  clock,
   input  wire slr_pkg::mac_cmd_type                  cmd,
   output logic signed [slr_pkg::SAMPLE_BITS-1:0]     result
);

   localparam int SB = slr_pkg::SAMPLE_BITS;
   localparam int FB = slr_pkg::FRAC_BITS;
   localparam int PB = slr_pkg::PROD_BITS;

   logic signed [SB:0]   diff;
   logic signed [FB:0]   phase_s;
   logic signed [PB-1:0] prod_ff;
   logic signed [PB-1:0] prod_in;
   logic signed [SB-1:0] base_ff;
   logic signed [SB-1:0] base_in;
   logic signed [PB-FB-1:0] shifted;
   logic signed [PB-FB-1:0] sum;

   // Difference times phase, registered before the final add.
   assign diff    = (SB+1)'(cmd.cur) - (SB+1)'(cmd.prev);
   assign phase_s = $signed({1'b0, cmd.phase});
   assign prod_in = cmd.load ? PB'(diff * phase_s) : prod_ff;
   assign base_in = cmd.load ? cmd.prev : base_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   // Arithmetic shift floors the scaled difference.
   assign shifted = prod_ff[PB-1:FB];
   assign sum     = (PB-FB)'(base_ff) + shifted;
   assign result  = sum[SB-1:0];

endmodule
`default_nettype wire

@@ hdl/stereo_linear_resampler_top.sv @@
`default_nettype none
// Stereo linear-interpolation resampler.
// The req channel takes one signed stereo source frame per transfer; the rsp
// channel gives zero or more interpolated frames for it, the last of them
// flagged with last_of_run (and ends_write when the frame carried write_end).
// Both channels move a transfer when valid is high and stall is low.
// The step register (byte address 0) sets source frames per output frame in
// unsigned 3.16 form; a write clears the phase so the next frame primes the
// history. req_stall stays high from a frame's transfer until the range check
// that ends its run. For each output the sequencer does a range check, two
// passes through the one shared multiply-add unit (left, then right) and a
// load of the output register. A stalled receiver holds the output register;
// the sequencer waits at its load step until the register is free, so nothing
// is lost. Reset restores the unit step, clears the phase, the history and the
// primed flag, and empties the output register.
module stereo_linear_resampler_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire slr_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output slr_pkg::rsp_type                           rsp_data,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [slr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [slr_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [slr_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready
);

   localparam int SB = slr_pkg::SAMPLE_BITS;
   localparam int FB = slr_pkg::FRAC_BITS;
   localparam int PHB = slr_pkg::PHASE_BITS;
   localparam int CB = slr_pkg::CNT_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL_L = 5'b00100,
      ST_MUL_R = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [PHB-1:0]        phase_ff, phase_in;
   logic signed [SB-1:0]  prev_l_ff, prev_l_in;
   logic signed [SB-1:0]  prev_r_ff, prev_r_in;
   logic                  primed_ff, primed_in;
   logic [CB-1:0]         cnt_ff, cnt_in;
   slr_pkg::req_type      cur_ff, cur_in;
   logic signed [SB-1:0]  left_res_ff, left_res_in;
   slr_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [slr_pkg::STEP_BITS-1:0] step;
   logic                          step_write;
   slr_pkg::mac_cmd_type          mac_cmd;
   logic signed [SB-1:0]          mac_result;
   logic [PHB-1:0]                next_phase;
   logic                          below_one;
   logic                          more;
   logic                          out_free;
   logic                          last;

   slr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .step       (step),
      .step_write (step_write)
   );

   // Operands for the shared unit: left channel first, then right.
   always_comb begin
      mac_cmd.load  = (state_ff == ST_MUL_L) || (state_ff == ST_MUL_R);
      mac_cmd.prev  = (state_ff == ST_MUL_L) ? prev_l_ff : prev_r_ff;
      mac_cmd.cur   = (state_ff == ST_MUL_L) ? cur_ff.left_sample : cur_ff.right_sample;
      mac_cmd.phase = phase_ff[FB-1:0];
   end

   slr_mac u_mac (
      .clock  (clock),
      .cmd    (mac_cmd),
      .result (mac_result)
   );

   // Phase tests for the run loop.
   assign next_phase = phase_ff + PHB'(step);
   assign below_one  = phase_ff < slr_pkg::PHASE_ONE;
   assign more       = below_one && (cnt_ff != CB'(slr_pkg::MAX_RESULTS));
   assign last       = (next_phase >= slr_pkg::PHASE_ONE) ||
                       (cnt_ff == CB'(slr_pkg::MAX_RESULTS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      primed_in    = primed_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      left_res_in  = left_res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_data;
               cnt_in   = '0;
               state_in = ST_CHECK;
               if (!primed_ff) begin
                  prev_l_in = req_data.left_sample;
                  prev_r_in = req_data.right_sample;
                  phase_in  = '0;
                  primed_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (more) begin
               state_in = ST_MUL_L;
            end else begin
               // End of run: step past the current frame.
               phase_in  = below_one ? '0 : (phase_ff - slr_pkg::PHASE_ONE);
               prev_l_in = cur_ff.left_sample;
               prev_r_in = cur_ff.right_sample;
               state_in  = ST_IDLE;
            end
         end
         ST_MUL_L: begin
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            left_res_in = mac_result;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in.left_out    = left_res_ff;
               rsp_in.right_out   = mac_result;
               rsp_in.last_of_run = last;
               rsp_in.ends_write  = last && cur_ff.write_end;
               rsp_valid_in       = 1'b1;
               phase_in           = next_phase;
               cnt_in             = cnt_ff + CB'(1);
               state_in           = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A step write restarts interpolation with the next frame.
      if (step_write) begin
         phase_in  = '0;
         primed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         primed_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         primed_ff    <= primed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      left_res_ff <= left_res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // Between frames the phase is below four.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (phase_ff[PHB-1] == 1'b0))
      else $error("phase out of range between frames");

   // A run never produces more than the output cap.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(slr_pkg::MAX_RESULTS))
      else $error("run count exceeds cap");

   // An accepted frame leaves the history primed, unless a step write comes with it.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !step_write) |=> (primed_ff && (state_ff == ST_CHECK)))
      else $error("frame accepted without priming");
`endif

endmodule
`default_nettype wire
